FILE: rtl/core/plt_pkg.sv
package plt_pkg;

    localparam int SLOT_COUNT_DEF = 2048;

    localparam int KEY_W      = 48;
    localparam int REQ_W      = 16;
    localparam int LVL_W      = 7;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_IDX_W = 11;
    localparam int TAG_W      = KEY_W + REQ_W;
    localparam int INFO_W     = LVL_W + REQ_W;
    localparam int HASH_W     = 32;

    // Low word of the Fibonacci multiplier; the low 32 bits of the 64-bit
    // product depend only on the low words of both operands.
    localparam logic [HASH_W-1:0] HASH_MULT_LO = 32'h7F4A_7C15;

    localparam logic [OUTCOME_W-1:0] OUT_CLAIMED   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ALREADY   = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_TAKEOVER  = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_WAIT      = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_RELEASED  = 3'd5;
    localparam logic [OUTCOME_W-1:0] OUT_NOT_OWNER = 3'd6;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

endpackage

FILE: rtl/core/plt_ram.sv
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/priority_lock_table_unit.sv
// Channel | Direction | Handshake                 | Payload
// request | in        | i_in_valid / o_in_ready   | i_action, i_object_key, i_requester_id,
//         |           |                           | i_priority_level
// result  | out       | o_out_valid / i_out_ready | o_outcome, o_holder_level, o_slot_index
//
// One transaction at a time: a hash step, then the hash is reduced, directly when SLOT_COUNT
// is a power of two (otherwise by reciprocal quotient, difference, final correction), then a
// tag/info memory read and a compare and write back for each probed slot. A lookup hitting
// its home slot passes ST_HASH, ST_MOD, ST_READ, ST_CHECK (ST_REM, ST_FIX too for other sizes);
// the next request is taken in ST_IDLE. After reset a clearing pass writes every slot with
// o_in_ready low. The result register frees the core: a new request is taken while a result
// waits, and the core only stalls in the compare cycle if the previous result is still not taken.
module priority_lock_table_unit #(
    parameter int SLOT_COUNT = plt_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [plt_pkg::KEY_W-1:0]         i_object_key,
    input  logic [plt_pkg::REQ_W-1:0]         i_requester_id,
    input  logic [plt_pkg::LVL_W-1:0]         i_priority_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [plt_pkg::OUTCOME_W-1:0]     o_outcome,
    output logic [plt_pkg::LVL_W-1:0]         o_holder_level,
    output logic [plt_pkg::SLOT_IDX_W-1:0]    o_slot_index
);

    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam bit IS_POW2 = (SLOT_COUNT == (1 << ADDR_W));
    localparam logic [ADDR_W-1:0] LAST_SLOT    = ADDR_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]  LAST_PROBE   = CNT_W'(SLOT_COUNT - 1);
    localparam logic [plt_pkg::HASH_W-1:0] SLOTS_HW = SLOT_COUNT[plt_pkg::HASH_W-1:0];
    // floor(2^32 / SLOT_COUNT): the quotient estimate is low by at most one
    localparam logic [63:0] RECIP_WIDE = (64'd1 << plt_pkg::HASH_W) / 64'(SLOT_COUNT);
    localparam logic [plt_pkg::HASH_W-1:0] RECIP = RECIP_WIDE[plt_pkg::HASH_W-1:0];

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_CHECK = 3'd5;
    localparam logic [2:0] ST_REM   = 3'd6;
    localparam logic [2:0] ST_FIX   = 3'd7;

    logic [2:0]                     r_state, n_state;
    logic [ADDR_W-1:0]              r_clr_addr, n_clr_addr;
    logic                           r_act;
    logic [plt_pkg::KEY_W-1:0]      r_key;
    logic [plt_pkg::REQ_W-1:0]      r_req;
    logic [plt_pkg::LVL_W-1:0]      r_lvl;
    logic [plt_pkg::HASH_W-1:0]     r_hash, n_hash;
    logic [plt_pkg::HASH_W-1:0]     r_quo, n_quo;
    logic [ADDR_W-1:0]              r_pos, n_pos;
    logic [CNT_W-1:0]               r_probes, n_probes;
    logic                           r_out_valid, n_out_valid;
    logic [plt_pkg::OUTCOME_W-1:0]  r_outcome, n_outcome;
    logic [plt_pkg::LVL_W-1:0]      r_holder, n_holder;
    logic [plt_pkg::SLOT_IDX_W-1:0] r_slot, n_slot;

    logic [plt_pkg::HASH_W-1:0]   hash_prod;
    logic [2*plt_pkg::HASH_W-1:0] quo_prod;
    logic [plt_pkg::HASH_W-1:0]   rem_diff;
    logic [ADDR_W-1:0]            rem_fix;
    logic [ADDR_W-1:0]            pos_next;
    logic [ADDR_W+plt_pkg::SLOT_IDX_W-1:0] pos_ext;

    logic                        in_fire;
    logic                        out_free;
    logic                        load_out;
    logic [plt_pkg::TAG_W-1:0]   tag_rd;
    logic [plt_pkg::INFO_W-1:0]  info_rd;
    logic [plt_pkg::TAG_W-1:0]   my_tag;
    logic [plt_pkg::INFO_W-1:0]  my_info;
    logic [plt_pkg::LVL_W-1:0]   old_lvl;
    logic [plt_pkg::REQ_W-1:0]   old_req;
    logic                        tag_empty;
    logic                        slot_hit;

    logic                        rd_en;
    logic                        tag_wr_en;
    logic                        info_wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [plt_pkg::TAG_W-1:0]   tag_wr_data;
    logic [plt_pkg::INFO_W-1:0]  info_wr_data;

    plt_ram #(
        .WIDTH (plt_pkg::TAG_W),
        .DEPTH (SLOT_COUNT)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (tag_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (tag_rd)
    );

    plt_ram #(
        .WIDTH (plt_pkg::INFO_W),
        .DEPTH (SLOT_COUNT)
    ) u_info_ram (
        .i_clk     (i_clk),
        .i_wr_en   (info_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (info_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pos),
        .o_rd_data (info_rd)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign hash_prod = r_key[plt_pkg::HASH_W-1:0] * plt_pkg::HASH_MULT_LO;

    // Reciprocal remainder: quotient estimate, difference below 2*SLOT_COUNT, one correction
    assign quo_prod = {{plt_pkg::HASH_W{1'b0}}, r_hash} * {{plt_pkg::HASH_W{1'b0}}, RECIP};
    assign rem_diff = r_hash - r_quo * SLOTS_HW;
    assign rem_fix  = (r_hash >= SLOTS_HW) ? ADDR_W'(r_hash - SLOTS_HW)
                                           : r_hash[ADDR_W-1:0];

    assign pos_next = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;
    assign pos_ext  = {{plt_pkg::SLOT_IDX_W{1'b0}}, r_pos};

    assign my_tag    = {r_key, r_req};
    assign my_info   = {r_lvl, r_req};
    assign old_lvl   = info_rd[plt_pkg::INFO_W-1:plt_pkg::REQ_W];
    assign old_req   = info_rd[plt_pkg::REQ_W-1:0];
    assign tag_empty = (tag_rd == '0);
    assign slot_hit  = tag_empty || (tag_rd[plt_pkg::TAG_W-1:plt_pkg::REQ_W] == r_key);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_hash      = r_hash;
        n_quo       = r_quo;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_out_valid = r_out_valid && !i_out_ready;
        n_outcome   = r_outcome;
        n_holder    = r_holder;
        n_slot      = r_slot;
        load_out    = 1'b0;
        rd_en       = 1'b0;
        tag_wr_en   = 1'b0;
        info_wr_en  = 1'b0;
        wr_addr     = r_pos;
        tag_wr_data = '0;
        info_wr_data = '0;

        unique case (r_state)
            ST_CLEAR: begin
                tag_wr_en  = 1'b1;
                info_wr_en = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                n_hash  = hash_prod;
                n_state = ST_MOD;
            end
            ST_MOD: begin
                n_probes = '0;
                if (IS_POW2) begin
                    n_pos   = r_hash[ADDR_W-1:0];
                    n_state = ST_READ;
                end else begin
                    n_quo   = quo_prod[2*plt_pkg::HASH_W-1:plt_pkg::HASH_W];
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                n_hash  = rem_diff;
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_pos   = rem_fix;
                n_state = ST_READ;
            end
            ST_READ: begin
                rd_en   = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!slot_hit && r_probes != LAST_PROBE) begin
                    n_pos    = pos_next;
                    n_probes = r_probes + 1'b1;
                    n_state  = ST_READ;
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    if (!slot_hit) begin
                        n_outcome = plt_pkg::OUT_FULL;
                        n_holder  = '0;
                        n_slot    = '0;
                    end else begin
                        n_holder = old_lvl;
                        n_slot   = pos_ext[plt_pkg::SLOT_IDX_W-1:0];
                        tag_wr_data = my_tag;
                        if (r_act == plt_pkg::ACT_ACQUIRE) begin
                            info_wr_data = my_info;
                            priority if (tag_rd == my_tag || old_req == r_req) begin
                                info_wr_en = 1'b1;
                                n_outcome  = plt_pkg::OUT_ALREADY;
                            end else if (tag_empty) begin
                                tag_wr_en  = 1'b1;
                                info_wr_en = 1'b1;
                                n_outcome  = plt_pkg::OUT_CLAIMED;
                            end else if (r_lvl > old_lvl) begin
                                tag_wr_en  = 1'b1;
                                info_wr_en = 1'b1;
                                n_outcome  = plt_pkg::OUT_TAKEOVER;
                            end else begin
                                n_outcome  = plt_pkg::OUT_WAIT;
                            end
                        end else begin
                            // release always drops the info word, the tag only for the owner
                            tag_wr_data = '0;
                            info_wr_en  = 1'b1;
                            if (tag_rd == my_tag) begin
                                tag_wr_en = 1'b1;
                                n_outcome = plt_pkg::OUT_RELEASED;
                            end else begin
                                n_outcome = plt_pkg::OUT_NOT_OWNER;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act <= i_action;
            r_key <= i_object_key;
            r_req <= i_requester_id;
            r_lvl <= i_priority_level;
        end
        r_hash    <= n_hash;
        r_quo     <= n_quo;
        r_pos     <= n_pos;
        r_probes  <= n_probes;
        r_outcome <= n_outcome;
        r_holder  <= n_holder;
        r_slot    <= n_slot;
    end

    assign o_out_valid    = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_holder_level = r_holder;
    assign o_slot_index   = r_slot;

    // A taken request blocks further requests until its result is produced
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Probe address stays inside the table
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_pos <= LAST_SLOT))
        else $error("probe address out of range");

    // Outside the clearing pass the memories are only written together with a result
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((tag_wr_en || info_wr_en) && r_state != ST_CLEAR) |=> o_out_valid)
        else $error("table write without a result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int          SLOTS        = plt_pkg::SLOT_COUNT_DEF;
    localparam int          KEY_W        = plt_pkg::KEY_W;
    localparam int          REQ_W        = plt_pkg::REQ_W;
    localparam int          LVL_W        = plt_pkg::LVL_W;
    localparam int          OUTCOME_W    = plt_pkg::OUTCOME_W;
    localparam int          SLOT_IDX_W   = plt_pkg::SLOT_IDX_W;
    localparam int          TAG_W        = plt_pkg::TAG_W;
    localparam int          INFO_W       = plt_pkg::INFO_W;
    localparam int          IDLE_PCT     = 20;
    localparam int          POOL_N       = 32;
    localparam int          DRAIN_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam logic [63:0] FIB_MULT     = 64'h9E37_79B9_7F4A_7C15;

    typedef struct packed {
        logic               act;
        logic [KEY_W-1:0]   key;
        logic [REQ_W-1:0]   req;
        logic [LVL_W-1:0]   lvl;
    } t_lock_req;

    typedef struct packed {
        logic [OUTCOME_W-1:0]  outcome;
        logic [LVL_W-1:0]      holder;
        logic [SLOT_IDX_W-1:0] slot;
    } t_lock_result;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic                  i_action         = 1'b0;
    logic [KEY_W-1:0]      i_object_key     = '0;
    logic [REQ_W-1:0]      i_requester_id   = '0;
    logic [LVL_W-1:0]      i_priority_level = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [OUTCOME_W-1:0]  o_outcome;
    logic [LVL_W-1:0]      o_holder_level;
    logic [SLOT_IDX_W-1:0] o_slot_index;

    // predictor copy of the lock store
    logic [TAG_W-1:0]  lock_tags [SLOTS];
    logic [INFO_W-1:0] lock_info [SLOTS];

    t_lock_req    requests_pending[$];
    t_lock_result results_due[$];
    int unsigned  requests_queued = 0;
    int unsigned  results_checked = 0;
    int unsigned  mismatches      = 0;
    int unsigned  cycle_count     = 0;
    bit           steady          = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_N];
    logic [REQ_W-1:0] id_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                      16'h8000, 16'hFFFF, 16'h5A5A, 16'hA5A5};

    priority_lock_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_object_key    (i_object_key),
        .i_requester_id  (i_requester_id),
        .i_priority_level(i_priority_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_outcome       (o_outcome),
        .o_holder_level  (o_holder_level),
        .o_slot_index    (o_slot_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned home_slot(logic [KEY_W-1:0] key);
        logic [63:0] prod;
        prod = {{(64-KEY_W){1'b0}}, key} * FIB_MULT;
        return prod[31:0] % SLOTS;
    endfunction

    function automatic t_lock_result lock_table_apply(logic act, logic [KEY_W-1:0] key,
                                                      logic [REQ_W-1:0] req,
                                                      logic [LVL_W-1:0] lvl);
        t_lock_result      res;
        logic [TAG_W-1:0]  own_tag;
        logic [TAG_W-1:0]  old_tag;
        logic [INFO_W-1:0] own_info;
        logic [LVL_W-1:0]  old_lvl;
        logic [REQ_W-1:0]  old_req;
        int unsigned       pos;
        bit                found;
        pos   = home_slot(key);
        found = 1'b0;
        for (int n = 0; n < SLOTS && !found; n++) begin
            if (lock_tags[pos] == '0 || lock_tags[pos][TAG_W-1:REQ_W] == key) begin
                found = 1'b1;
            end else begin
                pos = (pos + 1) % SLOTS;
            end
        end
        res.outcome = plt_pkg::OUT_FULL;
        res.holder  = '0;
        res.slot    = '0;
        if (!found) return res;

        own_tag     = {key, req};
        own_info    = {lvl, req};
        old_tag     = lock_tags[pos];
        old_lvl     = lock_info[pos][INFO_W-1:REQ_W];
        old_req     = lock_info[pos][REQ_W-1:0];
        res.holder  = old_lvl;
        res.slot    = SLOT_IDX_W'(pos);
        if (act == plt_pkg::ACT_ACQUIRE) begin
            // ownership wins over everything, even on an empty slot
            if (old_tag == own_tag || old_req == req) begin
                lock_info[pos] = own_info;
                res.outcome    = plt_pkg::OUT_ALREADY;
            end else if (old_tag == '0) begin
                lock_tags[pos] = own_tag;
                lock_info[pos] = own_info;
                res.outcome    = plt_pkg::OUT_CLAIMED;
            end else if (lvl > old_lvl) begin
                lock_tags[pos] = own_tag;
                lock_info[pos] = own_info;
                res.outcome    = plt_pkg::OUT_TAKEOVER;
            end else begin
                res.outcome    = plt_pkg::OUT_WAIT;
            end
        end else begin
            if (old_tag == own_tag) begin
                lock_tags[pos] = '0;
                res.outcome    = plt_pkg::OUT_RELEASED;
            end else begin
                res.outcome    = plt_pkg::OUT_NOT_OWNER;
            end
            lock_info[pos] = '0;
        end
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[KEY_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] key_at_slot(int unsigned slot);
        logic [KEY_W-1:0] k;
        k = rand_key();
        while (home_slot(k) != slot) k = rand_key();
        return k;
    endfunction

    function automatic logic [REQ_W-1:0] pick_id();
        if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, 7)];
        return REQ_W'($urandom);
    endfunction

    function automatic logic [LVL_W-1:0] rand_level();
        if ($urandom_range(0, 9) == 0) return LVL_W'($urandom_range(101, 127));
        return LVL_W'($urandom_range(0, 100));
    endfunction

    task automatic queue_req(logic act, logic [KEY_W-1:0] key, logic [REQ_W-1:0] req,
                             logic [LVL_W-1:0] lvl);
        requests_pending.push_back('{act, key, req, lvl});
        requests_queued++;
    endtask

    // every queued request has had its result checked
    task automatic wait_drained();
        while (results_checked < requests_queued) @(posedge i_clk);
    endtask

    // mostly acquire/contend/release sequences on a small colliding key set, some noise
    task automatic queue_random_traffic(int unsigned count);
        logic [KEY_W-1:0] key;
        logic [REQ_W-1:0] owner_id;
        logic [REQ_W-1:0] rival_id;
        int unsigned      target;
        target = requests_queued + count;
        while (requests_queued < target) begin
            key      = key_pool[$urandom_range(0, POOL_N - 1)];
            owner_id = pick_id();
            rival_id = pick_id();
            if ($urandom_range(0, 99) < 70) begin
                queue_req(plt_pkg::ACT_ACQUIRE, key, owner_id, rand_level());
                if ($urandom_range(0, 1))
                    queue_req(plt_pkg::ACT_ACQUIRE, key, owner_id, rand_level());
                if ($urandom_range(0, 99) < 60)
                    queue_req(plt_pkg::ACT_ACQUIRE, key, rival_id, rand_level());
                if ($urandom_range(0, 3) == 0)
                    queue_req(plt_pkg::ACT_RELEASE, key, rival_id, rand_level());
                if ($urandom_range(0, 4) != 0)
                    queue_req(plt_pkg::ACT_RELEASE, key,
                              $urandom_range(0, 1) ? owner_id : rival_id, rand_level());
            end else begin
                case ($urandom_range(0, 3))
                    0: key = rand_key();
                    1: key = $urandom_range(0, 1) ? '0 : '1;
                    default: ;
                endcase
                queue_req($urandom_range(0, 1) ? plt_pkg::ACT_RELEASE : plt_pkg::ACT_ACQUIRE,
                          key, $urandom_range(0, 1) ? REQ_W'($urandom) : owner_id,
                          LVL_W'($urandom_range(0, 127)));
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_lock_req nxt;
        bit        take;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                results_due.push_back(lock_table_apply(i_action, i_object_key,
                                                       i_requester_id, i_priority_level));
                take = 1'b1;
            end
            if (take) begin
                if (requests_pending.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = requests_pending.pop_front();
                    i_action         <= nxt.act;
                    i_object_key     <= nxt.key;
                    i_requester_id   <= nxt.req;
                    i_priority_level <= nxt.lvl;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_lock_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result transaction: outcome %0d slot %0d",
                           o_outcome, o_slot_index);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (o_outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, o_outcome);
                        mismatches++;
                    end
                    if (o_holder_level !== want.holder) begin
                        $error("holder_level: expected %0d, got %0d", want.holder,
                               o_holder_level);
                        mismatches++;
                    end
                    if (o_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                        mismatches++;
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** priority_lock_table_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_c;
        logic [KEY_W-1:0] key_d;
        logic [KEY_W-1:0] miss_key;
        logic [REQ_W-1:0] rq;
        logic [TAG_W-1:0] last_tag;
        bit               present;

        for (int s = 0; s < SLOTS; s++) begin
            lock_tags[s] = '0;
            lock_info[s] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero tag on key 0, refresh, wait, takeover, stale releases,
        // duplicate after a hole, wrap from the last slot
        key_a = key_at_slot(100);
        key_b = key_at_slot(100);
        while (key_b == key_a) key_b = key_at_slot(100);
        key_c = key_at_slot(SLOTS - 1);
        key_d = key_at_slot(SLOTS - 1);
        while (key_d == key_c) key_d = key_at_slot(SLOTS - 1);
        queue_req(plt_pkg::ACT_ACQUIRE, '0, 16'h0000, 7'd0);
        queue_req(plt_pkg::ACT_ACQUIRE, '0, 16'h0007, 7'd3);
        queue_req(plt_pkg::ACT_ACQUIRE, '0, 16'h0000, 7'd50);
        queue_req(plt_pkg::ACT_ACQUIRE, '0, 16'h0000, 7'd9);
        queue_req(plt_pkg::ACT_ACQUIRE, key_a, 16'h0005, 7'd10);
        queue_req(plt_pkg::ACT_ACQUIRE, key_a, 16'h0005, 7'd20);
        queue_req(plt_pkg::ACT_ACQUIRE, key_a, 16'h0006, 7'd20);
        queue_req(plt_pkg::ACT_ACQUIRE, key_a, 16'h0006, 7'd127);
        queue_req(plt_pkg::ACT_ACQUIRE, key_b, 16'h0002, 7'd1);
        queue_req(plt_pkg::ACT_RELEASE, key_a, 16'h0005, 7'd0);
        queue_req(plt_pkg::ACT_ACQUIRE, key_a, 16'h0000, 7'd0);
        queue_req(plt_pkg::ACT_RELEASE, key_a, 16'h0006, 7'd0);
        queue_req(plt_pkg::ACT_RELEASE, key_a, 16'h0006, 7'd0);
        queue_req(plt_pkg::ACT_ACQUIRE, key_b, 16'h0002, 7'd100);
        queue_req(plt_pkg::ACT_RELEASE, key_b, 16'h0002, 7'd0);
        queue_req(plt_pkg::ACT_ACQUIRE, key_c, 16'hFFFF, 7'd100);
        queue_req(plt_pkg::ACT_ACQUIRE, key_d, 16'h8000, 7'd64);
        queue_req(plt_pkg::ACT_ACQUIRE, '1, 16'hFFFF, 7'd127);
        queue_req(plt_pkg::ACT_RELEASE, '1, 16'hFFFF, 7'd0);
        queue_req(plt_pkg::ACT_RELEASE, key_d, 16'h8000, 7'd0);
        wait_drained();

        // key pool: random keys, chains sharing a home slot, keys wrapping at the end
        for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
        for (int i = 16; i < 28; i++) key_pool[i] = key_at_slot(home_slot(key_pool[i % 4]));
        for (int i = 28; i < POOL_N; i++) key_pool[i] = key_at_slot(SLOTS - 1 - (i % 2));

        queue_random_traffic(60);
        while (requests_pending.size() != 0) @(posedge i_clk);
        steady = 1'b1;
        queue_random_traffic(40);
        while (requests_pending.size() != 0) @(posedge i_clk);
        steady = 1'b0;
        queue_random_traffic(60);
        wait_drained();

        // fill every empty slot through its own home slot, then probe a full table
        steady = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            if (lock_tags[s] == '0) begin
                rq = REQ_W'($urandom_range(1, 65535));
                while (rq == lock_info[s][REQ_W-1:0]) rq = REQ_W'($urandom_range(1, 65535));
                queue_req(plt_pkg::ACT_ACQUIRE, key_at_slot(s), rq, rand_level());
            end
        end
        wait_drained();
        steady = 1'b0;

        do begin
            miss_key = rand_key();
            present  = 1'b0;
            for (int s = 0; s < SLOTS; s++)
                if (lock_tags[s][TAG_W-1:REQ_W] == miss_key) present = 1'b1;
        end while (present);
        last_tag = lock_tags[SLOTS-1];
        queue_req(plt_pkg::ACT_ACQUIRE, miss_key, pick_id(), rand_level());
        queue_req(plt_pkg::ACT_RELEASE, miss_key, pick_id(), rand_level());
        queue_req(plt_pkg::ACT_ACQUIRE, key_pool[0], pick_id(), rand_level());
        queue_req(plt_pkg::ACT_RELEASE, last_tag[TAG_W-1:REQ_W], last_tag[REQ_W-1:0], 7'd0);
        queue_req(plt_pkg::ACT_ACQUIRE, miss_key, pick_id(), rand_level());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("** priority_lock_table_unit: PASSED **");
        end else begin
            $display("** priority_lock_table_unit: FAILED **");
        end
        $finish;
    end

endmodule
